// ===== design/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned PIX_W     = 20;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned WIDE_W    = 66;
  localparam int unsigned UPC_W     = 3;

  localparam logic [2:0] REG_ITER_LIMIT = 3'd0;
  localparam logic [2:0] REG_LEFT_REAL  = 3'd1;
  localparam logic [2:0] REG_TOP_IMAG   = 3'd2;
  localparam logic [2:0] REG_REAL_STEP  = 3'd3;
  localparam logic [2:0] REG_IMAG_STEP  = 3'd4;

  // Four in Q8.56.
  localparam logic [PROD_W:0] BAIL_Q56 = (PROD_W + 1)'(4) << 56;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_CRE  = 3'd0;
  localparam upc_t UPC_CIM  = 3'd1;
  localparam upc_t UPC_INIT = 3'd2;
  localparam upc_t UPC_XX   = 3'd3;
  localparam upc_t UPC_YY   = 3'd4;
  localparam upc_t UPC_XY   = 3'd5;
  localparam upc_t UPC_UPD  = 3'd6;
  localparam upc_t UPC_FIN  = 3'd7;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_CRE  = 3'd1,
    MUL_CIM  = 3'd2,
    MUL_XX   = 3'd3,
    MUL_YY   = 3'd4,
    MUL_XY   = 3'd5
  } mul_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_LIMIT  = 2'd2,
    JMP_BAIL   = 2'd3
  } jmp_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     ld_cre;
    logic     ld_cim;
    logic     clr_z;
    logic     ld_xx;
    logic     ld_diff;
    logic     upd_z;
    logic     done;
    jmp_e     jmp;
    upc_t     target;
  } ctrl_t;

  typedef struct packed {
    logic limit_hit;
    logic bail;
  } status_t;

  typedef struct packed {
    logic        [LIMIT_W-1:0] iter_limit;
    logic signed [COORD_W-1:0] left_real;
    logic signed [COORD_W-1:0] top_imag;
    logic        [STEP_W-1:0]  real_step;
    logic        [STEP_W-1:0]  imag_step;
  } cfg_t;

  localparam ctrl_t CTRL_NOP = '{mul_sel: MUL_NONE, ld_cre: 1'b0, ld_cim: 1'b0,
                                 clr_z: 1'b0, ld_xx: 1'b0, ld_diff: 1'b0,
                                 upd_z: 1'b0, done: 1'b0, jmp: JMP_NEXT,
                                 target: UPC_CRE};

  function automatic ctrl_t ucode(input upc_t upc);
    ctrl_t w;
    w = CTRL_NOP;
    case (upc)
      UPC_CRE: begin
        w.mul_sel = MUL_CRE;
      end
      UPC_CIM: begin
        w.mul_sel = MUL_CIM;
        w.ld_cre  = 1'b1;
      end
      UPC_INIT: begin
        w.ld_cim = 1'b1;
        w.clr_z  = 1'b1;
      end
      UPC_XX: begin
        w.mul_sel = MUL_XX;
        w.jmp     = JMP_LIMIT;
        w.target  = UPC_FIN;
      end
      UPC_YY: begin
        w.mul_sel = MUL_YY;
        w.ld_xx   = 1'b1;
      end
      UPC_XY: begin
        w.mul_sel = MUL_XY;
        w.ld_diff = 1'b1;
        w.jmp     = JMP_BAIL;
        w.target  = UPC_FIN;
      end
      UPC_UPD: begin
        w.upd_z  = 1'b1;
        w.jmp    = JMP_ALWAYS;
        w.target = UPC_XX;
      end
      UPC_FIN: begin
        w.done   = 1'b1;
        w.jmp    = JMP_ALWAYS;
        w.target = UPC_FIN;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mbe_datapath.sv =====
`timescale 1ns / 1ps

module mbe_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mbe_pkg::POS_W-1:0]           row_i,
  input  logic [mbe_pkg::POS_W-1:0]           col_i,
  input  mbe_pkg::cfg_t                       cfg_i,
  input  mbe_pkg::ctrl_t                      ctrl_i,
  output mbe_pkg::status_t                    status_o,
  output logic [mbe_pkg::LIMIT_W-1:0]         iter_o
);

  localparam int unsigned OPW = mbe_pkg::COORD_W + 1;

  logic        [mbe_pkg::POS_W-1:0]   row_q, col_q;
  logic signed [mbe_pkg::PROD_W-1:0]  p_q, xx_q, diff_q;
  logic signed [mbe_pkg::COORD_W-1:0] cre_q, cim_q, x_q, y_q;
  logic        [mbe_pkg::LIMIT_W-1:0] iter_q;

  logic signed [OPW-1:0]              op_a, op_b;
  logic signed [2*OPW-1:0]            prod;
  logic                               mul_en;
  logic        [mbe_pkg::PROD_W:0]    mag_sum;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b1;
    case (ctrl_i.mul_sel)
      mbe_pkg::MUL_CRE: begin
        op_a = OPW'(col_q);
        op_b = OPW'(cfg_i.real_step);
      end
      mbe_pkg::MUL_CIM: begin
        op_a = OPW'(row_q);
        op_b = OPW'(cfg_i.imag_step);
      end
      mbe_pkg::MUL_XX: begin
        op_a = OPW'(x_q);
        op_b = OPW'(x_q);
      end
      mbe_pkg::MUL_YY: begin
        op_a = OPW'(y_q);
        op_b = OPW'(y_q);
      end
      mbe_pkg::MUL_XY: begin
        op_a = OPW'(x_q);
        op_b = OPW'(y_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod    = op_a * op_b;
  assign mag_sum = (mbe_pkg::PROD_W + 1)'(unsigned'(xx_q)) +
                   (mbe_pkg::PROD_W + 1)'(unsigned'(p_q));

  assign status_o.limit_hit = (iter_q >= cfg_i.iter_limit);
  assign status_o.bail      = (mag_sum > mbe_pkg::BAIL_Q56);
  assign iter_o             = iter_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (mul_en) begin
      p_q <= prod[mbe_pkg::PROD_W-1:0];
    end
    if (ctrl_i.ld_cre) begin
      cre_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(cfg_i.left_real) +
                              mbe_pkg::WIDE_W'(p_q));
    end
    if (ctrl_i.ld_cim) begin
      cim_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(cfg_i.top_imag) -
                              mbe_pkg::WIDE_W'(p_q));
    end
    if (ctrl_i.ld_xx) begin
      xx_q <= p_q;
    end
    if (ctrl_i.ld_diff) begin
      diff_q <= xx_q - p_q;
    end
    if (ctrl_i.clr_z) begin
      x_q <= '0;
      y_q <= '0;
    end else if (ctrl_i.upd_z) begin
      // The shift by one less fraction bit doubles the cross product.
      x_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(diff_q >>> mbe_pkg::FRAC_BITS) +
                            mbe_pkg::WIDE_W'(cre_q));
      y_q <= mbe_pkg::sat32(mbe_pkg::WIDE_W'(p_q >>> (mbe_pkg::FRAC_BITS - 1)) +
                            mbe_pkg::WIDE_W'(cim_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (ctrl_i.clr_z) begin
      iter_q <= '0;
    end else if (ctrl_i.upd_z) begin
      iter_q <= iter_q + mbe_pkg::LIMIT_W'(1);
    end
  end

endmodule

// ===== design/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// A pixel's result is valid once it escapes (tested at the XY step) or reaches the limit L (tested at the XX step).
// One item at a time; the next item is taken the cycle after a result is registered.
// Each iteration takes four microcode steps around one shared 33x33 multiplier.
// Reset (rst_ni low, asynchronous) restores the default view and a limit of 5000.

module mandelbrot_escape_time #(
  parameter int unsigned IMAGE_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // row [9:0], col [19:10], zero [23:20]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // escape_count [15:0], pixel_index [35:16], zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned PIX_FULL_W = mbe_pkg::POS_W + 14;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e               state_q, state_d;
  mbe_pkg::upc_t        upc_q, upc_d;
  mbe_pkg::cfg_t        cfg_q;
  mbe_pkg::ctrl_t       rom_word, ctrl;
  mbe_pkg::status_t     status;
  logic [mbe_pkg::LIMIT_W-1:0] iter;

  logic                        accept, jump, finish, out_free;
  logic [mbe_pkg::POS_W-1:0]   in_row, in_col;
  logic [PIX_FULL_W-1:0]       pix_full;
  logic [mbe_pkg::PIX_W-1:0]   pix_q;
  logic                        m_valid_q;
  logic [39:0]                 m_data_q;

  assign in_row = s_axis_tdata_i[9:0];
  assign in_col = s_axis_tdata_i[19:10];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign rom_word = mbe_pkg::ucode(upc_q);
  assign ctrl     = (state_q == ST_RUN) ? rom_word : mbe_pkg::CTRL_NOP;
  assign finish   = ctrl.done && out_free;

  always_comb begin
    case (ctrl.jmp)
      mbe_pkg::JMP_ALWAYS: jump = 1'b1;
      mbe_pkg::JMP_LIMIT:  jump = status.limit_hit;
      mbe_pkg::JMP_BAIL:   jump = status.bail;
      default:             jump = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    case (state_q)
      ST_IDLE: begin
        upc_d = mbe_pkg::UPC_CRE;
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_IDLE;
          upc_d   = mbe_pkg::UPC_CRE;
        end else if (jump) begin
          upc_d = ctrl.target;
        end else begin
          upc_d = upc_q + mbe_pkg::UPC_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        upc_d   = mbe_pkg::UPC_CRE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= mbe_pkg::UPC_CRE;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.iter_limit <= mbe_pkg::LIMIT_W'(5000);
      cfg_q.left_real  <= -32'sd536870912;
      cfg_q.top_imag   <= 32'sd281857229;
      cfg_q.real_step  <= mbe_pkg::STEP_W'(787201);
      cfg_q.imag_step  <= mbe_pkg::STEP_W'(787457);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mbe_pkg::REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data_i[mbe_pkg::LIMIT_W-1:0];
        mbe_pkg::REG_LEFT_REAL:  cfg_q.left_real  <= cfg_data_i;
        mbe_pkg::REG_TOP_IMAG:   cfg_q.top_imag   <= cfg_data_i;
        mbe_pkg::REG_REAL_STEP:  cfg_q.real_step  <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_IMAG_STEP:  cfg_q.imag_step  <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_full = PIX_FULL_W'(in_row) * PIX_FULL_W'(IMAGE_WIDTH) + PIX_FULL_W'(in_col);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_full[mbe_pkg::PIX_W-1:0];
    end
    if (finish) begin
      m_data_q <= {4'b0, pix_q, iter};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  mbe_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .row_i    (in_row),
    .col_i    (in_col),
    .cfg_i    (cfg_q),
    .ctrl_i   (ctrl),
    .status_o (status),
    .iter_o   (iter)
  );

endmodule

// ===== tb/sv/tb_mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
  import mbe_pkg::*;

  localparam int unsigned PIXELS_PER_ROW = 1024;
  localparam int unsigned ITEMS_PER_MODE = 250;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;
  localparam logic [64:0] FOUR_Q56       = 65'd4 << 56;

  localparam int unsigned SEND_IDLE_BY_MODE [4] = '{0, 64, 0, 34};
  localparam int unsigned RECV_STALL_BY_MODE[4] = '{0, 0, 64, 34};

  typedef struct packed {
    logic [LIMIT_W-1:0] count;
    logic [PIX_W-1:0]   index;
  } pixel_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_index_i     = REG_ITER_LIMIT;
  logic [31:0] cfg_data_i      = '0;

  logic        [LIMIT_W-1:0] view_limit = 16'd5000;
  logic signed [COORD_W-1:0] view_left  = -32'sd536870912;
  logic signed [COORD_W-1:0] view_top   = 32'sd281857229;
  logic        [STEP_W-1:0]  view_rstep = 31'd787201;
  logic        [STEP_W-1:0]  view_istep = 31'd787457;

  pixel_result_t pending_pixels[$];
  int unsigned   mismatch_count = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  longint        cycle_count    = 0;
  longint        cycle_budget   = 0;

  mandelbrot_escape_time #(
    .IMAGE_WIDTH(PIXELS_PER_ROW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  function automatic logic signed [COORD_W-1:0] clamp_q428(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    pixel_result_t r;
    longint        c_re;
    longint        c_im;
    longint        x;
    longint        y;
    longint        nx;
    longint        xx;
    longint        yy;
    longint        xy;
    logic [64:0]   mag;
    int unsigned   iter;
    bit            escaped;
    c_re = clamp_q428(longint'(view_left) + longint'(col) * longint'(view_rstep));
    c_im = clamp_q428(longint'(view_top) - longint'(row) * longint'(view_istep));
    x = 0;
    y = 0;
    iter = 0;
    escaped = 1'b0;
    while (!escaped && iter <= int'(view_limit)) begin
      xx = x * x;
      yy = y * y;
      mag = {1'b0, xx} + {1'b0, yy};
      if (mag > FOUR_Q56) begin
        escaped = 1'b1;
      end else begin
        xy = x * y;
        nx = clamp_q428(((xx - yy) >>> FRAC_BITS) + c_re);
        y = clamp_q428(((2 * xy) >>> FRAC_BITS) + c_im);
        x = nx;
        iter++;
      end
    end
    r.count = (iter < int'(view_limit)) ? 16'(iter) : view_limit;
    r.index = 20'(longint'(row) * PIXELS_PER_ROW + longint'(col));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("item with nothing pending", m_axis_tdata_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata_o[LIMIT_W-1:0] !== want.count) begin
          report_mismatch("escape_count", m_axis_tdata_o[LIMIT_W-1:0], want.count);
        end
        if (m_axis_tdata_o[LIMIT_W+PIX_W-1:LIMIT_W] !== want.index) begin
          report_mismatch("pixel_index", m_axis_tdata_o[LIMIT_W+PIX_W-1:LIMIT_W],
                          want.index);
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_ITER_LIMIT: view_limit = data[LIMIT_W-1:0];
      REG_LEFT_REAL:  view_left  = data;
      REG_TOP_IMAG:   view_top   = data;
      REG_REAL_STEP:  view_rstep = data[STEP_W-1:0];
      REG_IMAG_STEP:  view_istep = data[STEP_W-1:0];
      default: begin
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_view(input logic [15:0] limit, input logic [31:0] left,
                              input logic [31:0] top, input logic [31:0] rstep,
                              input logic [31:0] istep);
    write_reg(REG_ITER_LIMIT, {16'd0, limit});
    write_reg(REG_LEFT_REAL, left);
    write_reg(REG_TOP_IMAG, top);
    write_reg(REG_REAL_STEP, rstep);
    write_reg(REG_IMAG_STEP, istep);
  endtask

  task automatic send_pixel(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3 * view_limit + 12, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, col, row};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    pending_pixels.push_back(predict_pixel(row, col));
    cycle_budget += 8 * longint'(view_limit) + 128;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    drain_results();
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_reset_view();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd384, 10'd683);
    send_pixel(10'd767, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    settle_block();
  endtask

  task automatic test_iteration_limits();
    program_view(16'd0, 32'hE000_0000, 32'd322122547, 32'd786432, 32'd838861);
    send_pixel(10'd384, 10'd683);
    send_pixel(10'd0, 10'd0);
    settle_block();
    write_reg(REG_ITER_LIMIT, 32'd1);
    send_pixel(10'd384, 10'd683);
    settle_block();
    write_reg(REG_ITER_LIMIT, 32'd65535);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd384, 10'd683);
    settle_block();
  endtask

  task automatic test_coordinate_saturation();
    program_view(16'd16, 32'h7000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd1);
    settle_block();
    program_view(16'd16, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    settle_block();
  endtask

  task automatic test_spare_indexes();
    program_view(16'd20, 32'hE000_0000, 32'd322122547, 32'd786432, 32'd838861);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      write_reg(3'(i), $urandom());
    end
    send_pixel(10'd100, 10'd700);
    send_pixel(10'd383, 10'd600);
    send_pixel(10'd700, 10'd300);
    settle_block();
  endtask

  task automatic program_random_view();
    logic [15:0] limit;
    if ($urandom_range(99) < 85) begin
      limit = 16'($urandom_range(48, 1));
    end else begin
      limit = 16'($urandom_range(300, 49));
    end
    if ($urandom_range(99) < 80) begin
      program_view(limit, 32'(-603979776 + int'($urandom_range(738197504))),
                   32'(-80530637 + int'($urandom_range(429496730))),
                   $urandom_range(32'd1 << $urandom_range(20, 6)),
                   $urandom_range(32'd1 << $urandom_range(20, 6)));
    end else begin
      write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom());
      program_view(limit, $urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned batch;
    logic [9:0]  row;
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = SEND_IDLE_BY_MODE[m];
      recv_stall_pct = RECV_STALL_BY_MODE[m];
      sent = 0;
      while (sent < ITEMS_PER_MODE) begin
        program_random_view();
        batch = $urandom_range(50, 20);
        for (int k = 0; k < batch; k++) begin
          if ($urandom_range(99) < 85) begin
            row = 10'($urandom_range(767, 0));
          end else begin
            row = 10'($urandom_range(1023, 768));
          end
          send_pixel(row, 10'($urandom_range(1023, 0)));
          sent++;
          if (sent == ITEMS_PER_MODE / 2) begin
            drain_results();
          end
        end
        settle_block();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin : watchdog
    while (cycle_count <= 4 * cycle_budget + 50000) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_iteration_limits();
    test_coordinate_saturation();
    test_spare_indexes();
    test_random_frames();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbe_pkg.sv
design/mbe_datapath.sv
design/mandelbrot_escape_time.sv
tb/sv/tb_mandelbrot_escape_time.sv
